/* hdl/tspr_pkg.sv */
// shared types and constants for the tiled scanline pixel renderer
package tspr_pkg;

	localparam logic [1:0] OP_VWRITE = 2'd0;
	localparam logic [1:0] OP_PWRITE = 2'd1;
	localparam logic [1:0] OP_RENDER = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNSUPP  = 2'd1;
	localparam logic [1:0] ST_NOLAYER = 2'd2;

	localparam logic [1:0] CFG_DISPCNT = 2'd0;
	localparam logic [1:0] CFG_BGCNT   = 2'd1;
	localparam logic [1:0] CFG_HOFS    = 2'd2;
	localparam logic [1:0] CFG_VOFS    = 2'd3;

	localparam logic [2:0] MODE_TEXT   = 3'd0;
	localparam logic [2:0] MODE_DIRECT = 3'd3;
	localparam logic [2:0] MODE_PAGED  = 3'd4;

	localparam logic [17:0] PAGE_OFFSET = 18'h0A000;

	// which memory read the datapath launches
	typedef enum logic [2:0] {
		RD_NONE,
		RD_ENTRY,
		RD_TILE,
		RD_PAL_TILE,
		RD_DIRECT,
		RD_PAGED,
		RD_PAL_PAGED,
		RD_PAL_ZERO
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    do_vwrite;
		logic    do_pwrite;
		rd_sel_t rd;
		logic    out_fixed;
		logic    out_vram;
		logic    out_pal;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       blank;
		logic       none_enabled;
		logic [1:0] path;
	} dp_stat_t;

	localparam logic [1:0] PATH_FIXED = 2'd0;
	localparam logic [1:0] PATH_TEXT  = 2'd1;
	localparam logic [1:0] PATH_DIR   = 2'd2;
	localparam logic [1:0] PATH_PAGE  = 2'd3;

endpackage

/* hdl/tspr_ctrl.sv */
// sequencer that steps one item through its memory reads
module tspr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	output logic                busy,
	input  logic                out_free,
	input  tspr_pkg::dp_stat_t  stat,
	output tspr_pkg::dp_cmd_t   cmd
);
	import tspr_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DECODE, S_RD1, S_RD2, S_RD3, S_DONE} state_t;
	state_t state_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.rd = RD_NONE;
		cmd.load = in_fire;
		unique case (state_q)
			S_IDLE: ;
			S_DECODE: begin
				if (stat.op == OP_VWRITE) cmd.do_vwrite = 1'b1;
				else if (stat.op == OP_PWRITE) cmd.do_pwrite = 1'b1;
				else if (stat.op == OP_RENDER) begin
					if (stat.blank) cmd.rd = RD_NONE;
					else if (stat.none_enabled) cmd.rd = RD_PAL_ZERO;
					else begin
						unique case (stat.path)
							PATH_TEXT: cmd.rd = RD_ENTRY;
							PATH_DIR:  cmd.rd = RD_DIRECT;
							PATH_PAGE: cmd.rd = RD_PAGED;
							PATH_FIXED: cmd.rd = RD_NONE;
						endcase
					end
				end
			end
			S_RD1: begin
				if (stat.path == PATH_TEXT) cmd.rd = RD_TILE;
				else if (stat.path == PATH_PAGE) cmd.rd = RD_PAL_PAGED;
			end
			S_RD2: cmd.rd = RD_PAL_TILE;
			S_RD3: ;
			S_DONE: begin
				if (out_free) begin
					if (stat.blank) cmd.out_fixed = 1'b1;
					else if (stat.none_enabled) cmd.out_pal = 1'b1;
					else if (stat.path == PATH_FIXED) cmd.out_fixed = 1'b1;
					else if (stat.path == PATH_DIR) cmd.out_vram = 1'b1;
					else cmd.out_pal = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) state_q <= S_DECODE;
				S_DECODE: begin
					if (stat.op != OP_RENDER) state_q <= S_IDLE;
					else if (stat.blank || (!stat.none_enabled && stat.path == PATH_FIXED))
						state_q <= S_DONE;
					else if (stat.none_enabled || stat.path == PATH_DIR) state_q <= S_RD3;
					else state_q <= S_RD1;
				end
				S_RD1: state_q <= (stat.path == PATH_TEXT) ? S_RD2 : S_RD3;
				S_RD2: state_q <= S_RD3;
				S_RD3: state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE) else $error("item taken while busy");
	a_out_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_fixed || cmd.out_vram || cmd.out_pal) |-> state_q == S_DONE)
		else $error("result outside done");
	a_write_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_vwrite || cmd.do_pwrite) |=> state_q == S_IDLE)
		else $error("write did not retire");
endmodule

/* hdl/tspr_datapath.sv */
// memories, address generation and result register
module tspr_datapath #(
	parameter int VIDEO_BYTES     = 98304,
	parameter int LINE_WIDTH      = 240,
	parameter int PALETTE_ENTRIES = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         op,
	input  logic [15:0]        address,
	input  logic [15:0]        write_data,
	input  logic [7:0]         line,
	input  logic [7:0]         column,
	input  logic [15:0]        display_control,
	input  logic [63:0]        layer_controls,
	input  logic [39:0]        horizontal_scrolls,
	input  logic [39:0]        vertical_scrolls,
	input  tspr_pkg::dp_cmd_t  cmd,
	output tspr_pkg::dp_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        color,
	output logic [1:0]         status
);
	import tspr_pkg::*;

	localparam int VHALF = VIDEO_BYTES / 2;
	localparam int VAW   = $clog2(VHALF);
	localparam int PAW   = $clog2(PALETTE_ENTRIES);

	logic [15:0] vmem [VHALF];
	logic [15:0] pmem [PALETTE_ENTRIES];

	logic [1:0]  op_q;
	logic [15:0] addr_q, wdata_q;
	logic [7:0]  line_q, column_q;

	// layer choice
	logic [1:0]  layer_q, path_q, fstat_q;
	logic [15:0] lctl;
	logic [9:0]  lhs, lvs;
	logic        chosen_any, chosen_mos;
	logic [1:0]  chosen_ly;

	always_comb begin
		logic [1:0] prio;
		logic       mos, any;
		logic [1:0] ch;
		prio = 2'd0; mos = 1'b0; any = 1'b0; ch = 2'd0;
		for (int k = 0; k < 4; k++) begin
			if (display_control[8+k] &&
			    (k == 0 || layer_controls[16*k +: 2] > prio)) begin
				prio = layer_controls[16*k +: 2];
				ch = k[1:0];
				any = 1'b1;
				mos = mos | layer_controls[16*k+6];
			end
		end
		stat.op = op_q;
		stat.blank = display_control[7];
		stat.none_enabled = (display_control[15:8] == 8'd0);
		stat.path = path_q;
		lctl = layer_controls[16*layer_q +: 16];
		lhs = horizontal_scrolls[10*layer_q +: 10];
		lvs = vertical_scrolls[10*layer_q +: 10];
		chosen_any = any; chosen_mos = mos; chosen_ly = ch;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; addr_q <= address; wdata_q <= write_data;
			line_q <= line; column_q <= column;
			layer_q <= chosen_ly;
			unique case (display_control[2:0])
				MODE_TEXT: begin
					path_q  <= (chosen_mos || !chosen_any) ? PATH_FIXED : PATH_TEXT;
					fstat_q <= chosen_mos ? ST_UNSUPP : ST_NOLAYER;
				end
				MODE_DIRECT, MODE_PAGED: begin
					if (!display_control[10]) begin
						path_q <= PATH_FIXED; fstat_q <= ST_NOLAYER;
					end else begin
						path_q <= (display_control[2:0] == MODE_DIRECT) ? PATH_DIR : PATH_PAGE;
						fstat_q <= ST_OK;
					end
				end
				default: begin
					path_q <= PATH_FIXED; fstat_q <= ST_UNSUPP;
				end
			endcase
		end
	end

	// text address
	logic        wide, tall, c8;
	logic [9:0]  px, py;
	logic [6:0]  tx, ty;
	logic [2:0]  blk;
	logic [17:0] se_addr;
	assign wide = lctl[14];
	assign tall = lctl[15];
	assign c8   = lctl[7];
	always_comb begin
		logic [9:0] sx, sy;
		sx = {2'b0, column_q} + lhs;
		sy = {2'b0, line_q} + lvs;
		px = wide ? {1'b0, sx[8:0]} : {2'b0, sx[7:0]};
		py = tall ? {1'b0, sy[8:0]} : {2'b0, sy[7:0]};
		tx = px[9:3];
		ty = py[9:3];
		blk = {1'b0, 1'b0, tx[5]} + (wide ? {1'b0, ty[5], 1'b0} : {2'b0, ty[5]});
		se_addr = {3'b0, lctl[12:8], 10'b0} + {5'b0, blk, 10'b0}
		          + {7'b0, ty[4:0], tx[4:0]};
	end

	logic [15:0] se_q, vrd_q, prd_q;
	logic        cx_lo_q;
	logic [17:0] rd_byte;
	logic [2:0]  cx, row;
	always_comb begin
		logic [17:0] tb;
		cx  = vrd_q[10] ? ~px[2:0] : px[2:0];
		row = vrd_q[11] ? ~py[2:0] : py[2:0];
		tb  = {2'b0, lctl[3:2], 14'b0}
		      + (c8 ? {2'b0, vrd_q[9:0], 6'b0} : {3'b0, vrd_q[9:0], 5'b0})
		      + (c8 ? {12'b0, row, 3'b0} : {13'b0, row, 2'b0});
		rd_byte = c8 ? tb + {15'b0, cx} : tb + {16'b0, cx[2:1]};
	end

	logic [17:0] direct_h, paged_b;
	assign direct_h = 18'(line_q * LINE_WIDTH) + {10'b0, column_q};
	assign paged_b  = (display_control[4] ? PAGE_OFFSET : 18'd0) + direct_h;

	logic [17:0] vaddr;
	logic        vbyte_hi, vbyte_q;
	logic [9:0]  paddr;
	logic        v_en, p_en;
	logic [7:0]  pal_idx_tile, byte_sel;
	logic        v_zero_q, p_zero_q;
	always_comb begin
		vaddr = 18'd0; vbyte_hi = 1'b0; v_en = 1'b0; p_en = 1'b0; paddr = 10'd0;
		// a byte beyond video memory reads as zero
		byte_sel = v_zero_q ? 8'h00 : (vbyte_q ? vrd_q[15:8] : vrd_q[7:0]);
		pal_idx_tile = c8 ? byte_sel
		               : {se_q[15:12], cx_lo_q ? byte_sel[7:4] : byte_sel[3:0]};
		unique case (cmd.rd)
			RD_ENTRY:  begin v_en = 1'b1; vaddr = se_addr; end
			RD_TILE:   begin v_en = 1'b1; vaddr = {1'b0, rd_byte[17:1]}; vbyte_hi = rd_byte[0]; end
			RD_DIRECT: begin v_en = 1'b1; vaddr = direct_h; end
			RD_PAGED:  begin v_en = 1'b1; vaddr = {1'b0, paged_b[17:1]}; vbyte_hi = paged_b[0]; end
			RD_PAL_TILE:  begin p_en = 1'b1; paddr = {2'b0, pal_idx_tile}; end
			RD_PAL_PAGED: begin p_en = 1'b1; paddr = {2'b0, byte_sel}; end
			RD_PAL_ZERO:  begin p_en = 1'b1; paddr = 10'd0; end
			RD_NONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.do_vwrite && 32'(addr_q) < VHALF) vmem[addr_q[VAW-1:0]] <= wdata_q;
		if (cmd.do_pwrite && 32'(addr_q) < PALETTE_ENTRIES) pmem[addr_q[PAW-1:0]] <= wdata_q;
		if (v_en) begin
			vrd_q    <= vmem[vaddr[VAW-1:0]];
			v_zero_q <= !(32'(vaddr) < VHALF);
			vbyte_q  <= vbyte_hi;
		end
		if (p_en) begin
			prd_q    <= pmem[paddr[PAW-1:0]];
			p_zero_q <= !(32'(paddr) < PALETTE_ENTRIES);
		end
		if (cmd.rd == RD_ENTRY) se_q <= vmem[vaddr[VAW-1:0]];
		if (cmd.rd == RD_TILE) cx_lo_q <= cx[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_fixed || cmd.out_vram || cmd.out_pal) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.out_fixed) begin
			color  <= display_control[7] ? 16'hFFFF : 16'h0000;
			status <= display_control[7] ? ST_OK : fstat_q;
		end else if (cmd.out_vram) begin
			color <= v_zero_q ? 16'h0 : vrd_q; status <= ST_OK;
		end else if (cmd.out_pal) begin
			color <= p_zero_q ? 16'h0 : prd_q; status <= ST_OK;
		end
	end
endmodule

/* hdl/tiled_scanline_pixel_renderer.sv */
// top level of the tiled scanline pixel renderer
// one item at a time: a write retires at the decode step, a render steps through
// its reads (a text pixel reads screen entry, tile row and palette through the
// single video and palette ports in turn); a result waits in the output register,
// the next item is taken as soon as the sequencer is idle and a render holds at
// its last step while that register is still full. no clearing pass at reset
module tiled_scanline_pixel_renderer #(
	parameter int VIDEO_BYTES     = 98304,
	parameter int LINE_WIDTH      = 240,
	parameter int PALETTE_ENTRIES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // op[1:0], address[17:2], write_data[33:18], line[41:34], column[49:42]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // color[15:0], status[17:16]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import tspr_pkg::*;

	logic [15:0] dispcnt_q;
	logic [63:0] bgcnt_q;
	logic [39:0] hofs_q, vofs_q;

	// configuration beats always land at once
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dispcnt_q <= '0; bgcnt_q <= '0; hofs_q <= '0; vofs_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DISPCNT: dispcnt_q <= cfg_data[15:0];
				CFG_BGCNT:   bgcnt_q   <= cfg_data;
				CFG_HOFS:    hofs_q    <= cfg_data[39:0];
				CFG_VOFS:    vofs_q    <= cfg_data[39:0];
			endcase
		end
	end

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy, in_fire;
	logic [15:0] color;
	logic [1:0]  status;

	// accept whenever the sequencer is idle; the output register parts the sides
	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;

	tspr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .busy(busy),
		.out_free(!m_tvalid), .stat(stat), .cmd(cmd)
	);

	tspr_datapath #(
		.VIDEO_BYTES(VIDEO_BYTES), .LINE_WIDTH(LINE_WIDTH),
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.op(s_tdata[1:0]), .address(s_tdata[17:2]), .write_data(s_tdata[33:18]),
		.line(s_tdata[41:34]), .column(s_tdata[49:42]),
		.display_control(dispcnt_q), .layer_controls(bgcnt_q),
		.horizontal_scrolls(hofs_q), .vertical_scrolls(vofs_q),
		.cmd(cmd), .stat(stat), .out_valid(m_tvalid), .out_ready(m_tready),
		.color(color), .status(status)
	);

	assign m_tdata = {6'b0, status, color};

	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("pending result changed");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[17:16] != 2'd3) else $error("bad status code");
	a_err_color: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[17:16] != ST_OK) |-> m_tdata[15:0] == 16'h0)
		else $error("error result with colour");
endmodule

/* tb/tb.sv */
// self-checking testbench for the tiled scanline pixel renderer
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tspr_pkg::*;

	localparam int VRAM_HALVES = 98304 / 2;
	localparam int PAL_SIZE    = 512;
	localparam int SCREEN_W    = 240;
	localparam int SCREEN_H    = 160;

	// one input beat, unpacked
	typedef struct {
		logic [1:0]  op;
		logic [15:0] addr;
		logic [15:0] wdata;
		logic [7:0]  line;
		logic [7:0]  col;
	} req_t;

	// one rendered pixel as the block should return it
	typedef struct {
		logic [15:0] color;
		logic [1:0]  status;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // op[1:0], address[17:2], write_data[33:18], line[41:34], column[49:42]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // color[15:0], status[17:16]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	tiled_scanline_pixel_renderer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the block's memories and registers
	logic [15:0] vram_shadow [VRAM_HALVES];
	logic [15:0] pal_shadow [PAL_SIZE];
	logic [15:0] dispcnt_sh;
	logic [63:0] bgcnt_sh;
	logic [39:0] hofs_sh;
	logic [39:0] vofs_sh;

	req_t   pending_beats [$];
	pixel_t expected_pixels [$];
	int     err_count;
	bit     quiet;          // no idling on either side
	int     src_gap;
	int     sink_gap;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] vram_half(int unsigned idx);
		return (idx < VRAM_HALVES) ? vram_shadow[idx] : 16'h0000;
	endfunction

	function automatic logic [7:0] vram_byte(int unsigned byte_addr);
		logic [15:0] h;
		h = vram_half(byte_addr >> 1);
		return byte_addr[0] ? h[15:8] : h[7:0];
	endfunction

	function automatic logic [15:0] pal_read(int unsigned idx);
		return (idx < PAL_SIZE) ? pal_shadow[idx] : 16'h0000;
	endfunction

	// fetch chain of one text layer: screen entry, tile row, palette
	function automatic logic [15:0] text_layer_pixel(int layer, logic [7:0] line,
			logic [7:0] col);
		logic [15:0] ctl;
		logic [15:0] se;
		int unsigned hs, vs, wide, tall, deep, px, py, tx, ty, blk, se_addr;
		int unsigned cx, row, tile_addr, pidx;
		logic [7:0] b;
		ctl  = bgcnt_sh[16*layer +: 16];
		hs   = hofs_sh[10*layer +: 10];
		vs   = vofs_sh[10*layer +: 10];
		wide = ctl[14];
		tall = ctl[15];
		deep = ctl[7];
		px   = (col + hs) & ((256 << wide) - 1);
		py   = (line + vs) & ((256 << tall) - 1);
		tx   = px >> 3;
		ty   = py >> 3;
		blk  = (tx >> 5) + (ty >> 5) * (wide ? 2 : 1);
		se_addr = ctl[12:8] * 'h400 + blk * 'h400 + (ty & 31) * 32 + (tx & 31);
		se   = vram_half(se_addr);
		cx   = px & 7;
		row  = py & 7;
		if (se[10]) cx = 7 - cx;
		if (se[11]) row = 7 - row;
		tile_addr = ctl[3:2] * 'h4000 + se[9:0] * ('h20 << deep) + row * (4 << deep);
		if (deep) begin
			pidx = vram_byte(tile_addr + cx);
		end else begin
			b    = vram_byte(tile_addr + (cx >> 1));
			pidx = (se[15:12] << 4) | ((b >> ((cx & 1) * 4)) & 4'hF);
		end
		return pal_read(pidx);
	endfunction

	// expected color and status of one render beat
	function automatic pixel_t predict_pixel(logic [7:0] line, logic [7:0] col);
		pixel_t px;
		logic [2:0]  mode;
		logic [1:0]  prio;
		logic [15:0] ctl;
		logic        mosaic;
		int          chosen;
		int unsigned base;
		px.color  = 16'h0000;
		px.status = ST_OK;
		mode = dispcnt_sh[2:0];
		if (dispcnt_sh[7]) begin
			px.color = 16'hFFFF;
		end else if (dispcnt_sh[15:8] == 8'h00) begin
			px.color = pal_read(0);
		end else if (mode == MODE_TEXT) begin
			prio   = 2'd0;
			mosaic = 1'b0;
			chosen = -1;
			// layer 0 wins if on, later layers only with strictly higher priority
			for (int k = 0; k < 4; k++) begin
				ctl = bgcnt_sh[16*k +: 16];
				if (dispcnt_sh[8+k] && (k == 0 || ctl[1:0] > prio)) begin
					prio   = ctl[1:0];
					chosen = k;
					mosaic = mosaic | ctl[6];
				end
			end
			if (mosaic)
				px.status = ST_UNSUPP;
			else if (chosen < 0)
				px.status = ST_NOLAYER;
			else
				px.color = text_layer_pixel(chosen, line, col);
		end else if (mode == MODE_DIRECT || mode == MODE_PAGED) begin
			if (!dispcnt_sh[10]) begin
				px.status = ST_NOLAYER;
			end else if (mode == MODE_DIRECT) begin
				px.color = vram_half(line * SCREEN_W + col);
			end else begin
				base = dispcnt_sh[4] ? int'(PAGE_OFFSET) : 0;
				px.color = pal_read(vram_byte(base + line * SCREEN_W + col));
			end
		end else begin
			px.status = ST_UNSUPP;
		end
		return px;
	endfunction

	function automatic req_t make_req(int unsigned op, int unsigned addr, int unsigned wdata,
			int unsigned line, int unsigned col);
		req_t r;
		r.op = 2'(op); r.addr = 16'(addr); r.wdata = 16'(wdata);
		r.line = 8'(line); r.col = 8'(col);
		return r;
	endfunction

	// source side: holds a beat until taken, idles in random bursts
	always @(posedge clk or negedge arst_n) begin
		logic        nxt_valid;
		logic [55:0] nxt_data;
		req_t        r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				// accepted beat updates the shadow state or queues a pixel
				case (s_tdata[1:0])
					OP_VWRITE: if (s_tdata[17:2] < VRAM_HALVES) vram_shadow[s_tdata[17:2]] = s_tdata[33:18];
					OP_PWRITE: if (s_tdata[17:2] < PAL_SIZE) pal_shadow[s_tdata[17:2]] = s_tdata[33:18];
					OP_RENDER: expected_pixels.push_back(predict_pixel(s_tdata[41:34], s_tdata[49:42]));
					default: ;
				endcase
			end
			nxt_valid = s_tvalid && !s_tready;
			nxt_data  = s_tdata;
			if (!nxt_valid) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending_beats.size() > 0) begin
					if (!quiet && $urandom_range(0, 5) == 0) begin
						src_gap = $urandom_range(1, 7);
					end else begin
						r = pending_beats.pop_front();
						nxt_data  = {6'd0, r.col, r.line, r.wdata, r.addr, r.op};
						nxt_valid = 1'b1;
					end
				end
			end
			s_tvalid <= nxt_valid;
			s_tdata  <= nxt_data;
		end
	end

	// sink side: random stall bursts, checks each pixel against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected pixel beat color=%h status=%0d", m_tdata[15:0], m_tdata[17:16]);
					err_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata[15:0] !== want.color) begin
						$error("color: expected %h, got %h", want.color, m_tdata[15:0]);
						err_count++;
					end
					if (m_tdata[17:16] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tdata[17:16]);
						err_count++;
					end
				end
			end
			if (sink_gap > 0)
				sink_gap--;
			else if (!quiet && $urandom_range(0, 5) == 0)
				sink_gap = $urandom_range(1, 7);
			m_tready <= (sink_gap == 0);
		end
	end

	// wait until every beat is taken and every pixel has come back
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (pending_beats.size() > 0 || s_tvalid || expected_pixels.size() > 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_DISPCNT: dispcnt_sh = val[15:0];
			CFG_BGCNT:   bgcnt_sh   = val;
			CFG_HOFS:    hofs_sh    = val[39:0];
			default:     vofs_sh    = val[39:0];
		endcase
	endtask

	task automatic set_regs(logic [15:0] dc, logic [63:0] lc, logic [39:0] hs, logic [39:0] vs);
		write_reg(CFG_DISPCNT, {48'd0, dc});
		write_reg(CFG_BGCNT, lc);
		write_reg(CFG_HOFS, {24'd0, hs});
		write_reg(CFG_VOFS, {24'd0, vs});
	endtask

	// random mix: mostly on-screen renders, with memory writes and junk ops
	task automatic queue_random(int count);
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				if ($urandom_range(0, 9) == 0)
					pending_beats.push_back(make_req(OP_RENDER, $urandom, $urandom,
						$urandom, $urandom));
				else
					pending_beats.push_back(make_req(OP_RENDER, $urandom, $urandom,
						$urandom_range(0, SCREEN_H - 1), $urandom_range(0, SCREEN_W - 1)));
			end else if (pick < 82) begin
				pending_beats.push_back(make_req(OP_VWRITE,
					($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, VRAM_HALVES - 1)),
					$urandom, $urandom, $urandom));
			end else if (pick < 95) begin
				pending_beats.push_back(make_req(OP_PWRITE, $urandom_range(0, 1023), $urandom,
					$urandom, $urandom));
			end else begin
				pending_beats.push_back(make_req(2'd3, $urandom, $urandom, $urandom, $urandom));
			end
		end
	endtask

	task automatic queue_renders(int count);
		for (int i = 0; i < count; i++)
			pending_beats.push_back(make_req(OP_RENDER, $urandom, $urandom,
				$urandom_range(0, 255), $urandom_range(0, 255)));
	endtask

	// mosaic is rare so most text-mode pixels go through the full fetch chain
	function automatic logic [63:0] rand_layers();
		logic [63:0] lc;
		lc = {$urandom, $urandom};
		if ($urandom_range(0, 7) != 0)
			lc = lc & ~64'h0040_0040_0040_0040;
		return lc;
	endfunction

	function automatic logic [15:0] rand_dispcnt();
		logic [15:0] dc;
		int unsigned m;
		dc = 16'($urandom);
		if ($urandom_range(0, 5) != 0) dc[7] = 1'b0;
		m = $urandom_range(0, 9);
		if (m < 5)      dc[2:0] = MODE_TEXT;
		else if (m < 7) dc[2:0] = MODE_DIRECT;
		else if (m < 9) dc[2:0] = MODE_PAGED;
		return dc;
	endfunction

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		err_count = 0;
		quiet     = 1'b0;
		dispcnt_sh = '0;
		bgcnt_sh   = '0;
		hofs_sh    = '0;
		vofs_sh    = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// fill both memories so no render ever reads a never-written entry
		for (int a = 0; a < PAL_SIZE; a++)
			pending_beats.push_back(make_req(OP_PWRITE, a, $urandom, $urandom, $urandom));
		for (int a = 0; a < VRAM_HALVES; a++)
			pending_beats.push_back(make_req(OP_VWRITE, a, $urandom, $urandom, $urandom));
		drain();

		// directed beats under reset registers: field extremes and ignored writes
		pending_beats.push_back(make_req(OP_RENDER, 16'h0000, 16'h0000, 8'd0, 8'd0));
		pending_beats.push_back(make_req(OP_RENDER, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
		pending_beats.push_back(make_req(OP_VWRITE, 16'hFFFF, 16'h1234, 8'hFF, 8'hFF));
		pending_beats.push_back(make_req(OP_VWRITE, 16'(VRAM_HALVES), 16'hBEEF, 8'd0, 8'd0));
		pending_beats.push_back(make_req(OP_PWRITE, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0));
		pending_beats.push_back(make_req(OP_PWRITE, 16'd512, 16'h5555, 8'd0, 8'd0));
		pending_beats.push_back(make_req(OP_PWRITE, 16'd0, 16'h7FFF, 8'd0, 8'd0));
		pending_beats.push_back(make_req(2'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
		pending_beats.push_back(make_req(OP_RENDER, 16'd0, 16'd0, 8'd159, 8'd239));
		drain();

		// special cases: blank, the three supported modes and some unsupported ones, mosaic, no layer chosen, pages
		set_regs(16'h0F80, '0, '0, '0);               queue_renders(2); drain();
		set_regs(16'h0F00, 64'h0003_0002_0001_0000, '0, '0); queue_renders(3); drain();
		set_regs(16'h0F01, '0, '0, '0);               queue_renders(1); drain();
		set_regs(16'h0F02, '0, '0, '0);               queue_renders(1); drain();
		set_regs(16'h0F05, '0, '0, '0);               queue_renders(1); drain();
		set_regs(16'hFF7F, '0, '0, '0);               queue_renders(1); drain();
		set_regs(16'h0100, 64'h0000_0000_0000_0040, '0, '0); queue_renders(1); drain();
		set_regs(16'hF000, '0, '0, '0);               queue_renders(1); drain();
		set_regs(16'h0403, '0, '0, '0);               queue_renders(2); drain();
		set_regs(16'h0103, '0, '0, '0);               queue_renders(1); drain();
		set_regs(16'h0414, '0, '0, '0);               queue_renders(2); drain();
		set_regs(16'h0F00, 64'hFFBF_FFBF_FFBF_FFBF, '1, '1); queue_renders(3); drain();
		set_regs(16'hFFFF, '1, '1, '1);               queue_renders(1); drain();

		// random register settings, each followed by a random mix
		for (int p = 0; p < 12; p++) begin
			if (p == 11) quiet = 1'b1;
			set_regs(rand_dispcnt(), rand_layers(), 40'({$urandom, $urandom}),
				40'({$urandom, $urandom}));
			queue_random(110);
			drain();
		end

		if (err_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
hdl/tspr_pkg.sv
hdl/tspr_ctrl.sv
hdl/tspr_datapath.sv
hdl/tiled_scanline_pixel_renderer.sv
tb/tb.sv
